### design/gpc_pkg.sv
// Package for the grid path counter: field widths, modulus, action and
// register index codes, default grid limits. No dependencies.
package gpc_pkg;
    localparam int CNT_W = 30;
    localparam int DIM_W = 7;
    localparam int ACT_W = 2;
    localparam int CFG_IDX_W = 1;
    localparam int MAX_ROWS_DEF = 64;
    localparam int MAX_COLS_DEF = 64;

    localparam logic [CNT_W-1:0] PATH_MOD = CNT_W'(1000000007);
    localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(64);

    localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd0;
    localparam logic [ACT_W-1:0] ACT_MARK  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_COUNT = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT = 1'b1;
endpackage

### design/gpc_mod_add.sv
// Modular adder: (a + b) mod PATH_MOD for operands below the modulus.
// Depends on gpc_pkg.
module gpc_mod_add (
    input  logic [gpc_pkg::CNT_W-1:0] i_a,
    input  logic [gpc_pkg::CNT_W-1:0] i_b,
    output logic [gpc_pkg::CNT_W-1:0] o_sum
);
    import gpc_pkg::*;

    logic [CNT_W:0]   w_raw;
    logic [CNT_W-1:0] w_red;

    assign w_raw = {1'b0, i_a} + {1'b0, i_b};
    assign w_red = w_raw[CNT_W-1:0] - PATH_MOD;
    assign o_sum = (w_raw >= {1'b0, PATH_MOD}) ? w_red : w_raw[CNT_W-1:0];
endmodule

### design/grid_path_count_with_obstacles.sv
// Top level of the grid path counter: sequencer, blocked map, line store.
// Depends on gpc_pkg and gpc_mod_add.
//
//  channel   dir  handshake              payload
//  s         in   i_s_tvalid/o_s_tready  tdata: action[1:0] row[8:2] col[15:9]
//  m         out  o_m_tvalid/i_m_tready  tdata: path_count[29:0], zero pad
//  cfg       in   i_cfg_we               i_cfg_idx, i_cfg_data
//
// Count: one cell per cycle through the modular adder, plus a prep step
// per row to fetch the blocked-map row word.
// Mark: read-modify-write of the map. Clear: zeroes every map row in turn.
// After reset a clearing pass over all map rows runs before o_s_tready rises.
// A count result waits in its push cycle while the output register is full.
module grid_path_count_with_obstacles #(
    parameter int MAX_ROWS = gpc_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = gpc_pkg::MAX_COLS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [gpc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [gpc_pkg::DIM_W-1:0]     i_cfg_data,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [15:0]                   i_s_tdata,  // action, row, col
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [31:0]                   o_m_tdata   // path_count, pad
);
    import gpc_pkg::*;

    localparam int RW = $clog2(MAX_ROWS);
    localparam int CW = $clog2(MAX_COLS);
    localparam int DW = (RW + 1 > DIM_W) ? RW + 1 : DIM_W;

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_MARK = 3'd2;
    localparam logic [2:0] S_PREP = 3'd3;
    localparam logic [2:0] S_WALK = 3'd4;
    localparam logic [2:0] S_PUSH = 3'd5;

    logic [2:0]       r_state, n_state;
    logic [DIM_W-1:0] r_row_count, r_col_count;
    logic [RW-1:0]    r_walk_row, n_walk_row;
    logic [CW-1:0]    r_walk_col, n_walk_col;
    logic [CNT_W-1:0] r_left, n_left;
    logic [RW-1:0]    r_mark_row;
    logic [CW-1:0]    r_mark_col;
    logic             r_out_valid;
    logic [CNT_W-1:0] r_out_data;

    logic [MAX_COLS-1:0] map_mem [MAX_ROWS];
    logic [MAX_COLS-1:0] r_map_q;
    logic [CNT_W-1:0]    line_mem [MAX_COLS];
    logic [CNT_W-1:0]    r_line_q;

    logic [ACT_W-1:0] w_action;
    logic [DIM_W-1:0] w_row, w_col;
    logic             w_accept;
    logic [DW-1:0]    w_rows_ext;
    logic [RW-1:0]    w_last_row;
    logic [CW-1:0]    w_last_col;
    logic             w_mark_ok;
    logic             w_push_ok;

    logic [RW-1:0]       w_map_raddr, w_map_waddr;
    logic                w_map_we;
    logic [MAX_COLS-1:0] w_map_wdata;
    logic [CW-1:0]       w_line_raddr;
    logic                w_line_we;

    logic [CNT_W-1:0] w_up, w_sum;

    assign w_action = i_s_tdata[1:0];
    assign w_row    = i_s_tdata[8:2];
    assign w_col    = i_s_tdata[15:9];

    assign o_s_tready = (r_state == S_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {2'b00, r_out_data};
    assign w_push_ok  = !r_out_valid || i_m_tready;

    // Clamped grid size, as last row / column index
    assign w_rows_ext = DW'(r_row_count);
    assign w_last_row = (r_row_count == '0) ? '0 :
                        (w_rows_ext > DW'(MAX_ROWS)) ? RW'(MAX_ROWS - 1) :
                        RW'(w_rows_ext - DW'(1));
    assign w_last_col = (r_col_count == '0) ? '0 :
                        (r_col_count > DIM_W'(MAX_COLS)) ? CW'(MAX_COLS - 1) :
                        CW'(r_col_count - DIM_W'(1));

    assign w_mark_ok = (w_row != '0) && (w_col != '0) &&
                       (DW'(w_row) - DW'(1) <= DW'(w_last_row)) &&
                       (w_col - DIM_W'(1) <= DIM_W'(w_last_col));

    // Blocked map memory
    assign w_map_raddr = (r_state == S_IDLE) ? RW'(DW'(w_row) - DW'(1)) : r_walk_row;
    assign w_map_we    = (r_state == S_CLR) || (r_state == S_MARK);
    assign w_map_waddr = (r_state == S_MARK) ? r_mark_row : r_walk_row;
    assign w_map_wdata = (r_state == S_MARK) ?
                         (r_map_q | (MAX_COLS'(1) << r_mark_col)) : '0;

    always_ff @(posedge i_clk) begin
        if (w_map_we) begin
            map_mem[w_map_waddr] <= w_map_wdata;
        end
        r_map_q <= map_mem[w_map_raddr];
    end

    // Line store of the row above
    assign w_line_raddr = (r_state == S_WALK && r_walk_col != w_last_col) ?
                          r_walk_col + CW'(1) : '0;
    assign w_line_we    = (r_state == S_WALK);

    always_ff @(posedge i_clk) begin
        if (w_line_we) begin
            line_mem[r_walk_col] <= n_left;
        end
        r_line_q <= line_mem[w_line_raddr];
    end

    assign w_up = (r_walk_row != '0) ? r_line_q :
                  (r_walk_col == '0) ? CNT_W'(1) : '0;

    gpc_mod_add u_mod_add (
        .i_a   (w_up),
        .i_b   (r_left),
        .o_sum (w_sum)
    );

    always_comb begin
        n_state    = r_state;
        n_walk_row = r_walk_row;
        n_walk_col = r_walk_col;
        n_left     = r_left;
        unique case (r_state)
            S_CLR: begin
                n_walk_row = r_walk_row + RW'(1);
                if (r_walk_row == RW'(MAX_ROWS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_walk_row = '0;
                    if (w_action == ACT_CLEAR) begin
                        n_state = S_CLR;
                    end else if (w_action == ACT_MARK && w_mark_ok) begin
                        n_state = S_MARK;
                    end else if (w_action == ACT_COUNT) begin
                        n_state = S_PREP;
                    end
                end
            end
            S_MARK: begin
                n_state = S_IDLE;
            end
            S_PREP: begin
                n_walk_col = '0;
                n_left     = '0;
                n_state    = S_WALK;
            end
            S_WALK: begin
                n_left     = r_map_q[r_walk_col] ? '0 : w_sum;
                n_walk_col = r_walk_col + CW'(1);
                if (r_walk_col == w_last_col) begin
                    if (r_walk_row == w_last_row) begin
                        n_state = S_PUSH;
                    end else begin
                        n_walk_row = r_walk_row + RW'(1);
                        n_state    = S_PREP;
                    end
                end
            end
            S_PUSH: begin
                if (w_push_ok) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_walk_row  <= '0;
            r_walk_col  <= '0;
            r_left      <= '0;
            r_row_count <= DIM_RESET;
            r_col_count <= DIM_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_walk_row <= n_walk_row;
            r_walk_col <= n_walk_col;
            r_left     <= n_left;
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_ROW_COUNT) begin
                    r_row_count <= i_cfg_data;
                end else if (i_cfg_idx == CFG_COL_COUNT) begin
                    r_col_count <= i_cfg_data;
                end
            end
            if (r_state == S_PUSH && w_push_ok) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mark_row <= RW'(DW'(w_row) - DW'(1));
            r_mark_col <= CW'(w_col - DIM_W'(1));
        end
        if (r_state == S_PUSH && w_push_ok) begin
            r_out_data <= r_left;
        end
    end
endmodule
